FILE: rtl/lruc_pkg.sv
package lruc_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int SCAN_W   = $clog2(ENTRIES + 1);
  localparam int CNT_W    = 5;
  localparam int CAP_W    = 5;
  localparam int KEY_BITS = 32;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [OP_W-1:0] OP_GET   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_PUT   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_ERASE = OP_W'(2);
  localparam logic [OP_W-1:0] OP_PIN   = OP_W'(3);
  localparam logic [OP_W-1:0] OP_UNPIN = OP_W'(4);
  localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(5);

  typedef struct packed {
    logic             start;
    logic             clear_scan;
    logic             scan_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             apply;
    logic             load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic evict_more;
  } dp_stat_t;

endpackage

FILE: rtl/lruc_if.sv
interface lruc_req_if;
  import lruc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [KEY_BITS-1:0]     lookup_key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink (input valid, input opcode, input lookup_key, input write_value,
                output ready);
endinterface

interface lruc_rsp_if;
  import lruc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    success;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, output success, output read_value, output entry_count,
                  input ready);
  modport sink (input valid, input success, input read_value, input entry_count,
                output ready);
endinterface

FILE: rtl/lruc_ctrl.sv
module lruc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lruc_pkg::dp_stat_t  stat_i,
  output lruc_pkg::ctrl_cmd_t cmd_o
);
  import lruc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SCAN_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.rd_addr = cnt_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start      = 1'b1;
          cmd_o.clear_scan = 1'b1;
          cnt_d            = '0;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        // the compare stage sees each read in the cycle after it is issued
        cmd_o.scan_rd = (cnt_q < SCAN_W'(ENTRIES));
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SCAN_W'(ENTRIES)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (stat_i.evict_more) begin
          // one victim dropped, rescan for the next one and a free slot
          cmd_o.apply      = 1'b1;
          cmd_o.clear_scan = 1'b1;
          cnt_d            = '0;
          state_d          = S_SCAN;
        end else if (out_free) begin
          cmd_o.apply    = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_idle_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.apply)
    else $error("state update while idle");

  a_load_not_evicting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !stat_i.evict_more && out_free)
    else $error("response loaded during eviction or into a full slot");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_SCAN && cnt_q == '0)
    else $error("accepted request did not start a scan");

endmodule

FILE: rtl/lruc_dpath.sv
module lruc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lruc_pkg::ctrl_cmd_t                 cmd_i,
  output lruc_pkg::dp_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [lruc_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  logic [lruc_pkg::OP_W-1:0]           opcode_i,
  input  logic [lruc_pkg::KEY_BITS-1:0]       lookup_key_i,
  input  logic signed [lruc_pkg::VAL_W-1:0]   write_value_i,
  output logic                                success_o,
  output logic signed [lruc_pkg::VAL_W-1:0]   read_value_o,
  output logic [lruc_pkg::CNT_W-1:0]          entry_count_o
);
  import lruc_pkg::*;

  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    cap_eff;
  logic [OP_W-1:0]     op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]    val_q;
  logic                first_q;

  logic [ENTRIES-1:0]  valid_q, valid_n;
  logic [ENTRIES-1:0]  pinned_q, pinned_n;
  logic [IDX_W-1:0]    rec_q [ENTRIES];
  logic [IDX_W-1:0]    rec_n [ENTRIES];
  logic [CNT_W-1:0]    count_q, count_n;

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0]    val_mem [ENTRIES];
  logic [KEY_BITS-1:0] rd_key_q;
  logic [VAL_W-1:0]    rd_val_q;
  logic                cmp_vld_q;
  logic [IDX_W-1:0]    cmp_idx_q;

  // scan results
  logic                hit_q, hit_pin_q;
  logic [IDX_W-1:0]    hit_idx_q, hit_rec_q;
  logic [VAL_W-1:0]    hit_val_q;
  logic                best_q;
  logic [IDX_W-1:0]    best_idx_q, best_rec_q;
  logic                free_q;
  logic [IDX_W-1:0]    free_idx_q;

  logic                c_valid, c_pin;
  logic [IDX_W-1:0]    c_rec;
  logic                take_hit, take_best, take_free;

  logic                ok;
  logic [VAL_W-1:0]    rd;
  logic                evict_more;
  logic                key_we, val_we;
  logic [IDX_W-1:0]    wr_idx;
  logic                drop_en, touch_en, ins_en, pin_set, pin_clr, clr_all;
  logic [IDX_W-1:0]    drop_idx, r_ref;

  logic                out_succ_q;
  logic [VAL_W-1:0]    out_rdv_q;
  logic [CNT_W-1:0]    out_cnt_q;

  assign cap_eff = (cap_q > CAP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_q);

  assign stat_o.evict_more = evict_more;
  assign success_o         = out_succ_q;
  assign read_value_o      = $signed(out_rdv_q);
  assign entry_count_o     = out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= opcode_i;
      key_q <= lookup_key_i;
      val_q <= $unsigned(write_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    if (val_we) begin
      val_mem[wr_idx] <= val_q;
    end
    if (cmd_i.scan_rd) begin
      rd_key_q <= key_mem[cmd_i.rd_addr];
      rd_val_q <= val_mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmd_i.rd_addr;
  end

  // compare stage: key match, oldest unpinned, lowest free slot
  assign c_valid   = valid_q[cmp_idx_q];
  assign c_pin     = pinned_q[cmp_idx_q];
  assign c_rec     = rec_q[cmp_idx_q];
  assign take_hit  = cmp_vld_q && c_valid && (rd_key_q == key_q) && !hit_q;
  assign take_best = cmp_vld_q && c_valid && !c_pin && (!best_q || (c_rec < best_rec_q));
  assign take_free = cmp_vld_q && !c_valid && !free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      best_q <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.clear_scan) begin
      hit_q  <= 1'b0;
      best_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_q <= 1'b1;
      end
      if (take_best) begin
        best_q <= 1'b1;
      end
      if (take_free) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q <= cmp_idx_q;
      hit_pin_q <= c_pin;
      hit_rec_q <= c_rec;
      hit_val_q <= rd_val_q;
    end
    if (take_best) begin
      best_idx_q <= cmp_idx_q;
      best_rec_q <= c_rec;
    end
    if (take_free) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  always_comb begin
    ok         = 1'b0;
    rd         = '0;
    evict_more = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_idx     = hit_idx_q;
    drop_en    = 1'b0;
    drop_idx   = hit_idx_q;
    touch_en   = 1'b0;
    ins_en     = 1'b0;
    pin_set    = 1'b0;
    pin_clr    = 1'b0;
    clr_all    = 1'b0;
    r_ref      = hit_rec_q;
    unique case (op_q)
      OP_GET: begin
        if (hit_q) begin
          ok       = 1'b1;
          rd       = hit_val_q;
          touch_en = !hit_pin_q;
        end
      end
      OP_PUT: begin
        priority if (hit_q) begin
          val_we   = 1'b1;
          touch_en = !hit_pin_q;
        end else if (first_q && ((cap_eff == '0) ||
                                 ((count_q == cap_eff) && !best_q))) begin
          // refused: no room and nothing evictable
        end else if (count_q >= cap_eff) begin
          if (best_q) begin
            drop_en    = 1'b1;
            drop_idx   = best_idx_q;
            r_ref      = best_rec_q;
            evict_more = 1'b1;
          end else begin
            // pinned entries alone overfill: the new key is dropped
            ok = 1'b1;
          end
        end else begin
          ins_en = 1'b1;
          key_we = 1'b1;
          val_we = 1'b1;
          wr_idx = free_idx_q;
          ok     = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit_q) begin
          drop_en = 1'b1;
          ok      = 1'b1;
        end
      end
      OP_PIN: begin
        if (hit_q && !hit_pin_q) begin
          pin_set = 1'b1;
          ok      = 1'b1;
        end
      end
      OP_UNPIN: begin
        if (hit_q && hit_pin_q) begin
          pin_clr  = 1'b1;
          touch_en = 1'b1;
          ok       = 1'b1;
        end
      end
      OP_CLEAR: begin
        clr_all = 1'b1;
        ok      = 1'b1;
      end
      default: begin
      end
    endcase
    // write enables only fire on the committing cycle
    key_we = key_we && cmd_i.apply;
    val_we = val_we && cmd_i.apply;
  end

  always_comb begin
    valid_n  = valid_q;
    pinned_n = pinned_q;
    rec_n    = rec_q;
    count_n  = count_q;
    // close the gap left by the removed or touched rank
    for (int i = 0; i < ENTRIES; i++) begin
      if ((drop_en || touch_en) && valid_q[i] && (rec_q[i] > r_ref)) begin
        rec_n[i] = rec_q[i] - 1'b1;
      end
    end
    if (touch_en) begin
      rec_n[hit_idx_q] = IDX_W'(count_q - 1'b1);
    end
    if (drop_en) begin
      valid_n[drop_idx]  = 1'b0;
      pinned_n[drop_idx] = 1'b0;
      count_n            = count_q - 1'b1;
    end
    if (ins_en) begin
      valid_n[free_idx_q]  = 1'b1;
      pinned_n[free_idx_q] = 1'b0;
      rec_n[free_idx_q]    = IDX_W'(count_q);
      count_n              = count_q + 1'b1;
    end
    if (pin_set) begin
      pinned_n[hit_idx_q] = 1'b1;
    end
    if (pin_clr) begin
      pinned_n[hit_idx_q] = 1'b0;
    end
    if (clr_all) begin
      valid_n  = '0;
      pinned_n = '0;
      count_n  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rec_n[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      pinned_q <= '0;
      rec_q    <= '{default: '0};
      count_q  <= '0;
      first_q  <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        valid_q  <= valid_n;
        pinned_q <= pinned_n;
        rec_q    <= rec_n;
        count_q  <= count_n;
      end
      if (cmd_i.start) begin
        first_q <= 1'b1;
      end else if (cmd_i.apply) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_succ_q <= ok;
      out_rdv_q  <= rd;
      out_cnt_q  <= count_n;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == $countones(valid_q))
    else $error("entry count out of step with valid slots");

  a_pinned_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pinned_q & ~valid_q) == '0)
    else $error("pinned flag on an empty slot");

  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && ins_en |-> free_q)
    else $error("insert without a free slot");

endmodule

FILE: rtl/lru_cache_with_pinning_top.sv
// LRU key/value cache, 16 entries, with pinning.
// req channel (valid/ready): opcode, lookup_key, write_value. One request is
// taken at a time; ready is high only while the block is idle.
// rsp channel (valid/ready): success, read_value, entry_count, one response
// per request, in order.
// cfg_we_i/cfg_wdata_i write the capacity limit; write only while idle.
// Each request scans all slots through the key/value RAM read port, one slot
// a cycle, in the steps accept, scan and decide. The response is loaded into
// the output register in the decide step, and the next request can be taken
// once the block is back in idle. A put that must evict several entries
// (capacity lowered below the count) rescans all slots for each extra
// victim.
// The response sits in an output register; if the receiver stalls, the next
// request is still taken and scanned, and only its commit waits for the slot.
// Reset empties the cache, clears all pins and sets the capacity to 16; no
// clearing pass is needed.
module lru_cache_with_pinning_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lruc_req_if.sink                   req,
  lruc_rsp_if.source                 rsp,
  input  logic                       cfg_we_i,
  input  logic [lruc_pkg::CAP_W-1:0] cfg_wdata_i
);
  import lruc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lruc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lruc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (req.opcode),
    .lookup_key_i  (req.lookup_key),
    .write_value_i (req.write_value),
    .success_o     (rsp.success),
    .read_value_o  (rsp.read_value),
    .entry_count_o (rsp.entry_count)
  );

endmodule

FILE: dv/lruc_tb_pkg.sv
`timescale 1ns / 100ps
package lruc_tb_pkg;
  import lruc_pkg::*;

  // opcodes the block must treat as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = OP_W'(6);
  localparam logic [OP_W-1:0] OP_SPARE_7 = OP_W'(7);

  typedef struct packed {
    logic             success;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
  } lru_rsp_t;

  class lru_pin_scoreboard;
    bit                  live   [ENTRIES];
    bit                  locked [ENTRIES];
    logic [KEY_BITS-1:0] tag    [ENTRIES];
    logic [VAL_W-1:0]    data   [ENTRIES];
    int unsigned         age    [ENTRIES];  // rank among live slots, larger is newer
    int unsigned         n_held;
    int unsigned         cap_reg;
    lru_rsp_t            rsp_q[$];
    int                  errors = 0;
    int                  n_checked = 0;

    function void empty_cache();
      for (int i = 0; i < ENTRIES; i++) begin
        live[i]   = 1'b0;
        locked[i] = 1'b0;
        age[i]    = 0;
      end
      n_held = 0;
    endfunction

    function void reset_state();
      empty_cache();
      cap_reg = CAP_RESET;
    endfunction

    function void write_capacity(logic [CAP_W-1:0] c);
      cap_reg = c;
    endfunction

    function int find_key(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && tag[i] == k) return i;
      return -1;
    endfunction

    function void drop(int s);
      int unsigned r;
      r = age[s];
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && age[i] > r) age[i]--;
      live[s]   = 1'b0;
      locked[s] = 1'b0;
      n_held--;
    endfunction

    function void promote(int s);
      int unsigned r;
      r = age[s];
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && age[i] > r) age[i]--;
      age[s] = n_held - 1;
    endfunction

    function int oldest_unlocked();
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && !locked[i] && (best < 0 || age[i] < age[best])) best = i;
      return best;
    endfunction

    // predict the response of one accepted request and queue it
    function void note_request(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] k,
                               logic [VAL_W-1:0] v);
      int          s;
      int          victim;
      int unsigned cap_eff;
      lru_rsp_t    e;
      cap_eff = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
      e = '0;
      s = find_key(k);
      case (op)
        OP_GET: begin
          if (s >= 0) begin
            if (!locked[s]) promote(s);
            e.read_value = data[s];
            e.success    = 1'b1;
          end
        end
        OP_PUT: begin
          if (s >= 0) begin
            data[s] = v;
            if (!locked[s]) promote(s);
          end else if (cap_eff != 0 && !(n_held == cap_eff && oldest_unlocked() < 0)) begin
            while (n_held + 1 > cap_eff) begin
              victim = oldest_unlocked();
              if (victim < 0) break;
              drop(victim);
            end
            // pinned entries alone may still overflow: then the new key is dropped
            if (n_held + 1 <= cap_eff) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (!live[i]) begin
                  live[i]   = 1'b1;
                  locked[i] = 1'b0;
                  tag[i]    = k;
                  data[i]   = v;
                  age[i]    = n_held;
                  n_held++;
                  break;
                end
              end
            end
            e.success = 1'b1;
          end
        end
        OP_ERASE: begin
          if (s >= 0) begin
            drop(s);
            e.success = 1'b1;
          end
        end
        OP_PIN: begin
          if (s >= 0 && !locked[s]) begin
            locked[s] = 1'b1;
            e.success = 1'b1;
          end
        end
        OP_UNPIN: begin
          if (s >= 0 && locked[s]) begin
            locked[s] = 1'b0;
            promote(s);
            e.success = 1'b1;
          end
        end
        OP_CLEAR: begin
          empty_cache();
          e.success = 1'b1;
        end
        default: ;
      endcase
      e.entry_count = CNT_W'(n_held);
      rsp_q.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ERROR response %0d: %s", $time, n_checked, msg);
    endtask

    task check_response(logic ok, logic [VAL_W-1:0] rd, logic [CNT_W-1:0] cnt);
      lru_rsp_t e;
      if (rsp_q.size() == 0) begin
        report($sformatf("no request pending (success=%0b read=%h count=%0d)", ok, rd, cnt));
        return;
      end
      e = rsp_q[0];
      rsp_q.delete(0);
      if (ok !== e.success)
        report($sformatf("success %b, expected %b", ok, e.success));
      if (rd !== e.read_value)
        report($sformatf("read_value %h, expected %h", rd, e.read_value));
      if (cnt !== e.entry_count)
        report($sformatf("entry_count %0d, expected %0d", cnt, e.entry_count));
      n_checked++;
    endtask
  endclass

endpackage

FILE: dv/tb_lru_cache_with_pinning_top.sv
`timescale 1ns / 100ps
module tb_lru_cache_with_pinning_top;
  import lruc_pkg::*;
  import lruc_tb_pkg::*;

  localparam int NUM_ITEMS  = 1550;
  localparam int POOL_SIZE  = 24;
  localparam int TIMEOUT_NS = 20_000_000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  bit               req_burst;
  bit               rsp_burst;
  int unsigned      sent;

  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  lru_pin_scoreboard   cache_sb;

  lruc_req_if req_if ();
  lruc_rsp_if rsp_if ();

  lru_cache_with_pinning_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  // response side: random ready stalls, check every accepted response
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rsp_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      cache_sb.check_response(rsp_if.success, rsp_if.read_value, rsp_if.entry_count);
    end
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] k,
                          input logic [VAL_W-1:0] v);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.lookup_key  <= k;
    req_if.write_value <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    cache_sb.note_request(op, k, v);
    sent++;
  endtask

  // hold off new requests until every response is back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (cache_sb.rsp_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cache_sb.write_capacity(c);
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 26) return OP_GET;
    if (r < 58) return OP_PUT;
    if (r < 67) return OP_ERASE;
    if (r < 79) return OP_PIN;
    if (r < 93) return OP_UNPIN;
    if (r < 95) return OP_CLEAR;
    if (r < 97) return OP_SPARE_6;
    if (r < 99) return OP_SPARE_7;
    return OP_GET;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 92) return '0;
    if (r < 96) return '1;
    return $urandom();
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return CAP_W'(0);
    if (r < 22) return CAP_W'(ENTRIES);
    if (r < 30) return CAP_W'($urandom_range(ENTRIES + 1, 31));
    return CAP_W'($urandom_range(1, ENTRIES - 1));
  endfunction

  initial begin
    int unsigned phase_len;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= OP_GET;
    req_if.lookup_key  <= '0;
    req_if.write_value <= '0;
    req_burst = 1'b0;
    rsp_burst = 1'b0;
    sent      = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    cache_sb = new();
    cache_sb.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // basic operations and field extremes
    send_req(OP_GET,     32'h0000_0001, 32'h0);
    send_req(OP_PUT,     32'h0000_0000, 32'h8000_0000);
    send_req(OP_PUT,     32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_req(OP_PUT,     32'h0000_0000, 32'h0000_0005);   // update existing key
    send_req(OP_GET,     32'h0000_0000, 32'hFFFF_FFFF);
    send_req(OP_PIN,     32'h0000_0000, 32'h0);
    send_req(OP_PIN,     32'h0000_0000, 32'h0);           // already pinned
    send_req(OP_PUT,     32'h0000_0000, 32'hFFFF_FFFF);   // update pinned entry
    send_req(OP_UNPIN,   32'h0000_0000, 32'h0);
    send_req(OP_UNPIN,   32'h0000_0000, 32'h0);           // not pinned
    send_req(OP_ERASE,   32'hFFFF_FFFF, 32'h0);
    send_req(OP_ERASE,   32'hFFFF_FFFF, 32'h0);           // miss
    send_req(OP_SPARE_6, 32'h0000_0000, 32'h1234_5678);
    send_req(OP_SPARE_7, 32'h0000_0000, 32'h1234_5678);
    send_req(OP_CLEAR,   32'h0000_0000, 32'h0);
    // zero capacity refuses inserts
    drain();
    set_capacity(CAP_W'(0));
    send_req(OP_PUT,     32'h0000_0001, 32'h11);
    // full with every entry pinned refuses inserts
    drain();
    set_capacity(CAP_W'(2));
    send_req(OP_PUT,     32'h0000_0001, 32'h11);
    send_req(OP_PUT,     32'h0000_0002, 32'h22);
    send_req(OP_PIN,     32'h0000_0001, 32'h0);
    send_req(OP_PIN,     32'h0000_0002, 32'h0);
    send_req(OP_PUT,     32'h0000_0003, 32'h33);
    // capacity dropped below pinned count: victims go, then the new key itself
    drain();
    set_capacity(CAP_W'(ENTRIES));
    send_req(OP_PUT,     32'h0000_0003, 32'h33);
    send_req(OP_PUT,     32'h0000_0004, 32'h44);
    drain();
    set_capacity(CAP_W'(1));
    send_req(OP_PUT,     32'h0000_0005, 32'h55);
    send_req(OP_GET,     32'h0000_0005, 32'h0);
    drain();
    set_capacity(CAP_W'(31));                             // saturates at ENTRIES

    // random phases, each at its own capacity; state carries across phases
    while (sent < NUM_ITEMS) begin
      drain();
      set_capacity(pick_capacity());
      req_burst = ($urandom_range(0, 3) == 0);
      rsp_burst = ($urandom_range(0, 3) == 0);
      foreach (key_pool[i])
        if ($urandom_range(0, 2) == 0) key_pool[i] = $urandom();
      phase_len = $urandom_range(30, 150);
      repeat (phase_len) begin
        send_req(pick_op(), pick_key(), $urandom());
        if ($urandom_range(0, 79) == 0) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (cache_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lruc_pkg.sv
rtl/lruc_if.sv
rtl/lruc_ctrl.sv
rtl/lruc_dpath.sv
rtl/lru_cache_with_pinning_top.sv
dv/lruc_tb_pkg.sv
dv/tb_lru_cache_with_pinning_top.sv
